/* sv/noise_gate_hold_smoothed_macros.svh */
// assertion macros for the noise gate checker
`ifndef NOISE_GATE_HOLD_SMOOTHED_MACROS_SVH
`define NOISE_GATE_HOLD_SMOOTHED_MACROS_SVH

// same-cycle implication, reset masks the check
`define NGH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define NGH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/ngh_pkg.sv */
// shared types, constants and helpers of the noise gate
`timescale 1ns / 1ps

package ngh_pkg;

	localparam int SMP_W = 16;
	localparam int Q_W = 25;
	localparam int ENV_W = 40;
	localparam int HL_W = 17;
	localparam int IDX_W = 3;
	localparam int PROD_W = ENV_W + Q_W;

	localparam int HOLD_LIMIT_DEF = 131071;

	localparam logic [Q_W-1:0] Q24_ONE = Q_W'(1) << (Q_W - 1);

	localparam logic [SMP_W-1:0] THRESHOLD_RST = 16'd3277;
	localparam logic [Q_W-1:0] ATTACK_RST = 25'd75918;
	localparam logic [Q_W-1:0] RELEASE_RST = 25'd3170;
	localparam logic [Q_W-1:0] DETECTOR_RST = 25'd7607;
	localparam logic [HL_W-1:0] HOLD_LEN_RST = 17'd882;
	localparam logic [Q_W-1:0] RANGE_RST = 25'd16777216;
	localparam logic ENABLE_RST = 1'b1;

	typedef enum logic [IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_ATTACK    = 3'd1,
		REG_RELEASE   = 3'd2,
		REG_DETECTOR  = 3'd3,
		REG_HOLD_LEN  = 3'd4,
		REG_RANGE     = 3'd5,
		REG_ENABLE    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

	// coefficients above one act as one
	function automatic logic [Q_W-1:0] coeff_sat(input logic [Q_W-1:0] c);
		return (c > Q24_ONE) ? Q24_ONE : c;
	endfunction

endpackage

/* sv/noise_gate_hold_smoothed.sv */
// noise gate with peak envelope, hold counter and smoothed gain
//
//  port group   dir  transfer when            content
//  in_*         in   in_valid & in_ready      sample_in
//  out_*        out  out_valid & out_ready    sample_out, gate_open
//  cfg_*        in   cfg_we                   register index and value
//
// an enabled sample runs three 25-step bit-serial multiplies (envelope decay, gain step,
// output gain) in one shared unit before the next input transfer; the decay multiply is
// skipped when the input rises above the envelope
// a disabled sample skips the multiplies and goes straight to the finish state
// reset clears the state and loads the register defaults, no clearing pass
// the next sample is taken while a result waits; a finished sample stalls until it is taken
`timescale 1ns / 1ps

module noise_gate_hold_smoothed #(
	parameter int HOLD_LIMIT = ngh_pkg::HOLD_LIMIT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [ngh_pkg::SMP_W-1:0] sample_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [ngh_pkg::SMP_W-1:0] sample_out,
	output logic                             gate_open,
	input  logic                             cfg_we,
	input  logic [ngh_pkg::IDX_W-1:0]        cfg_addr,
	input  logic [ngh_pkg::Q_W-1:0]          cfg_wdata
);
	import ngh_pkg::*;

	localparam int HW = $clog2(HOLD_LIMIT + 1);
	localparam int CW = (HW > HL_W) ? HW : HL_W;
	localparam logic [CW-1:0] HLIM = CW'(HOLD_LIMIT);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ENV   = 8'b0000_0010,
		S_HOLD  = 8'b0000_0100,
		S_GAIN  = 8'b0000_1000,
		S_OGO   = 8'b0001_0000,
		S_OMUL  = 8'b0010_0000,
		S_OCALC = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [SMP_W-1:0] thr_q;
	logic [Q_W-1:0]   att_q;
	logic [Q_W-1:0]   rel_q;
	logic [Q_W-1:0]   det_q;
	logic [HL_W-1:0]  hlen_q;
	logic [Q_W-1:0]   range_q;
	logic             en_q;

	logic [ENV_W-1:0] env_q;
	logic [HW-1:0]    hold_q;
	logic [Q_W-1:0]   gain_q;

	logic [SMP_W-1:0] mag_q;
	logic             neg_q;
	logic             up_q;
	logic             open_q;
	logic [SMP_W-1:0] res_smp_q;
	logic             res_open_q;
	logic             out_valid_q;
	logic [SMP_W-1:0] sample_out_q;
	logic             gate_open_q;

	logic             in_xfer;
	logic [SMP_W-1:0] raw;
	logic             neg_in;
	logic [SMP_W-1:0] mag_in;
	logic [ENV_W-1:0] mag24_in;
	logic             rise_in;

	logic             above;
	logic [CW-1:0]    hl_ext;
	logic [HW-1:0]    hold_max;
	logic [HW-1:0]    hold_new;
	logic             open_now;
	logic [Q_W-1:0]   target;
	logic             gain_up;

	logic             mul_start;
	logic [ENV_W-1:0] mul_d;
	logic [Q_W-1:0]   mul_c;
	mul_stat_t        mul_stat;
	logic [PROD_W-1:0] mul_prod;

	logic [ENV_W-1:0] env_dec;
	logic [Q_W-1:0]   gain_step;
	logic [ENV_W-1:0] out_prod;
	logic [ENV_W+SMP_W-2:0] scaled;
	logic [SMP_W-1:0] ymag;
	logic [SMP_W-1:0] ymag_sat;
	logic             out_free;
	logic             out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_FIN) && out_free;

	// input magnitude
	assign raw      = sample_in;
	assign neg_in   = raw[SMP_W-1];
	assign mag_in   = neg_in ? (~raw + 1'b1) : raw;
	assign mag24_in = {mag_in, 24'd0};
	assign rise_in  = mag24_in > env_q;

	// hold and gate decision
	assign above    = env_q >= {thr_q, 24'd0};
	assign hl_ext   = CW'(hlen_q);
	assign hold_max = (hl_ext > HLIM) ? HW'(HLIM) : HW'(hl_ext);
	assign hold_new = above ? hold_max : ((hold_q != '0) ? hold_q - 1'b1 : hold_q);
	assign open_now = above || (hold_new != '0);
	assign target   = open_now ? Q24_ONE : Q24_ONE - coeff_sat(range_q);
	assign gain_up  = target > gain_q;

	// multiplier operand select
	always_comb begin
		mul_start = 1'b0;
		mul_d     = '0;
		mul_c     = '0;
		case (state_q)
			S_IDLE: begin
				mul_start = in_xfer && en_q && !rise_in;
				mul_d     = env_q - mag24_in;
				mul_c     = coeff_sat(det_q);
			end
			S_HOLD: begin
				mul_start = 1'b1;
				mul_d     = ENV_W'(gain_up ? target - gain_q : gain_q - target);
				mul_c     = coeff_sat(gain_up ? att_q : rel_q);
			end
			S_OGO: begin
				mul_start = 1'b1;
				mul_d     = ENV_W'(gain_q);
				mul_c     = Q_W'(mag_q);
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	ngh_bitmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.d_in   (mul_d),
		.c_in   (mul_c),
		.stat   (mul_stat),
		.prod   (mul_prod)
	);

	assign env_dec   = mul_prod[PROD_W-2:Q_W-1];
	assign gain_step = mul_prod[2*Q_W-2:Q_W-1];
	assign out_prod  = mul_prod[ENV_W-1:0];
	assign scaled    = {out_prod, 15'd0} - {15'd0, out_prod};
	assign ymag      = scaled[ENV_W+SMP_W-2:ENV_W-1];
	assign ymag_sat  = (ymag > 16'd32767) ? 16'd32767 : ymag;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THRESHOLD_RST;
			att_q   <= ATTACK_RST;
			rel_q   <= RELEASE_RST;
			det_q   <= DETECTOR_RST;
			hlen_q  <= HOLD_LEN_RST;
			range_q <= RANGE_RST;
			en_q    <= ENABLE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_THRESHOLD: thr_q   <= cfg_wdata[SMP_W-1:0];
				REG_ATTACK:    att_q   <= cfg_wdata;
				REG_RELEASE:   rel_q   <= cfg_wdata;
				REG_DETECTOR:  det_q   <= cfg_wdata;
				REG_HOLD_LEN:  hlen_q  <= cfg_wdata[HL_W-1:0];
				REG_RANGE:     range_q <= cfg_wdata;
				REG_ENABLE:    en_q    <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and gate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			env_q       <= '0;
			hold_q      <= '0;
			gain_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (!en_q) begin
							state_q <= S_FIN;
						end else if (rise_in) begin
							env_q   <= mag24_in;
							state_q <= S_HOLD;
						end else begin
							state_q <= S_ENV;
						end
					end
				end
				S_ENV: begin
					if (mul_stat.done) begin
						env_q   <= env_q - env_dec;
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					hold_q  <= hold_new;
					state_q <= S_GAIN;
				end
				S_GAIN: begin
					if (mul_stat.done) begin
						gain_q  <= up_q ? gain_q + gain_step : gain_q - gain_step;
						state_q <= S_OGO;
					end
				end
				S_OGO: begin
					state_q <= S_OMUL;
				end
				S_OMUL: begin
					if (mul_stat.done) begin
						state_q <= S_OCALC;
					end
				end
				S_OCALC: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-sample datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mag_q      <= mag_in;
			neg_q      <= neg_in;
			res_smp_q  <= raw;
			res_open_q <= 1'b1;
		end
		if (state_q == S_HOLD) begin
			up_q   <= gain_up;
			open_q <= open_now;
		end
		if (state_q == S_OCALC) begin
			res_smp_q  <= neg_q ? (~ymag_sat + 1'b1) : ymag_sat;
			res_open_q <= open_q;
		end
		if (out_load) begin
			sample_out_q <= res_smp_q;
			gate_open_q  <= res_open_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign gate_open  = gate_open_q;

endmodule

/* sv/ngh_bitmul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module ngh_bitmul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ngh_pkg::ENV_W-1:0]     d_in,
	input  logic [ngh_pkg::Q_W-1:0]       c_in,
	output ngh_pkg::mul_stat_t            stat,
	output logic [ngh_pkg::PROD_W-1:0]    prod
);
	import ngh_pkg::*;

	localparam int CNT_W = $clog2(Q_W + 1);
	localparam logic [CNT_W-1:0] STEPS = CNT_W'(Q_W);

	logic [ENV_W-1:0] acc_q;
	logic [Q_W-1:0]   lo_q;
	logic [Q_W-1:0]   c_q;
	logic [ENV_W-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [ENV_W:0]   sum;

	assign sum = {1'b0, acc_q} + (c_q[0] ? {1'b0, d_q} : {(ENV_W + 1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			lo_q  <= '0;
			c_q   <= c_in;
			d_q   <= d_in;
		end else if (busy_q) begin
			acc_q <= sum[ENV_W:1];
			lo_q  <= {sum[0], lo_q[Q_W-1:1]};
			c_q   <= {1'b0, c_q[Q_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod = {acc_q, lo_q};

endmodule

/* sv/ngh_checker.sv */
// port-level checks of the noise gate and their binding
`timescale 1ns / 1ps
`include "noise_gate_hold_smoothed_macros.svh"

module ngh_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic signed [ngh_pkg::SMP_W-1:0] sample_in,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [ngh_pkg::SMP_W-1:0] sample_out,
	input logic                             gate_open,
	input logic                             cfg_we,
	input logic [ngh_pkg::IDX_W-1:0]        cfg_addr,
	input logic [ngh_pkg::Q_W-1:0]          cfg_wdata
);

	// a stalled result holds
	`NGH_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(sample_out) && $stable(gate_open), "stalled result changed")

	// one sample at a time: busy right after a transfer
	`NGH_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready,
		"input taken while a sample is in work")

	// a new result appears only when a sample finishes
	`NGH_ASSERT_IMP(a_out_from_work, $rose(out_valid), $past(!in_ready),
		"result appeared while idle")

	// finishing a sample always leaves a result behind
	`NGH_ASSERT_IMP(a_done_has_out, $rose(in_ready), out_valid,
		"sample finished without a result")

endmodule

bind noise_gate_hold_smoothed ngh_checker u_ngh_checker (.*);

/* tb/noise_gate_hold_smoothed_checker.sv */
// checker for the noise gate: watches config writes and both channels, predicts and compares
`timescale 1ns / 1ps

module noise_gate_hold_smoothed_checker #(
	parameter int HOLD_MAX = ngh_pkg::HOLD_LIMIT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [ngh_pkg::SMP_W-1:0] sample_in,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [ngh_pkg::SMP_W-1:0] sample_out,
	input  logic                      gate_open,
	input  logic                      cfg_we,
	input  logic [ngh_pkg::IDX_W-1:0] cfg_addr,
	input  logic [ngh_pkg::Q_W-1:0]   cfg_wdata,
	output int                        fail_count,
	output int                        outstanding,
	output int                        results_seen,
	output int                        open_seen
);
	import ngh_pkg::*;

	localparam logic [63:0] UNITY = 64'd1 << 24;

	typedef struct packed {
		logic [SMP_W-1:0] smp;
		logic             open;
	} gated_t;

	gated_t gated_q[$];
	gated_t want_r;

	logic [SMP_W-1:0] thr_r;
	logic [Q_W-1:0]   atk_r;
	logic [Q_W-1:0]   rel_r;
	logic [Q_W-1:0]   det_r;
	logic [HL_W-1:0]  hold_len_r;
	logic [Q_W-1:0]   range_r;
	logic             en_r;

	logic [ENV_W-1:0] env_q;
	logic [HL_W-1:0]  hold_ctr;
	logic [Q_W-1:0]   gain_q;

	int mismatches;
	int checked;
	int opened;

	function automatic logic [63:0] unity_clip(input logic [63:0] c);
		return (c > UNITY) ? UNITY : c;
	endfunction

	function automatic logic [63:0] step_toward(input logic [63:0] s, input logic [63:0] t,
			input logic [63:0] alpha);
		logic [63:0] a;
		a = unity_clip(alpha);
		if (t > s) begin
			return s + (((t - s) * a) >> 24);
		end
		return s - (((s - t) * a) >> 24);
	endfunction

	task automatic gate_sample(input logic [SMP_W-1:0] x, output gated_t r);
		logic        neg;
		logic        above;
		logic        open_now;
		logic [63:0] mag;
		logic [63:0] mag24;
		logic [63:0] hmax;
		logic [63:0] tgt;
		logic [63:0] alpha;
		logic [63:0] prod;
		logic [63:0] ymag;
		neg = x[SMP_W-1];
		mag = neg ? (64'h10000 - 64'(x)) : 64'(x);
		if (!en_r) begin
			r.smp = x;
			r.open = 1'b1;
		end else begin
			mag24 = mag << 24;
			if (mag24 > 64'(env_q)) begin
				env_q = ENV_W'(mag24);
			end else begin
				env_q = ENV_W'(step_toward(64'(env_q), mag24, 64'(det_r)));
			end
			above = 64'(env_q) >= (64'(thr_r) << 24);
			hmax = (64'(hold_len_r) > 64'(HOLD_MAX)) ? 64'(HOLD_MAX) : 64'(hold_len_r);
			if (above) begin
				hold_ctr = HL_W'(hmax);
			end else if (hold_ctr != 0) begin
				hold_ctr = hold_ctr - 1'b1;
			end
			open_now = above || (hold_ctr != 0);
			tgt = open_now ? UNITY : UNITY - unity_clip(64'(range_r));
			alpha = (tgt > 64'(gain_q)) ? 64'(atk_r) : 64'(rel_r);
			gain_q = Q_W'(step_toward(64'(gain_q), tgt, alpha));
			prod = mag * 64'(gain_q);
			ymag = (prod * 64'd32767) >> 39;
			if (ymag > 64'd32767) begin
				ymag = 64'd32767;
			end
			r.smp = neg ? SMP_W'(64'h10000 - ymag) : SMP_W'(ymag);
			r.open = open_now;
		end
	endtask

	task automatic report(input string what);
		$display("%0t ns: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_r = THRESHOLD_RST;
			atk_r = ATTACK_RST;
			rel_r = RELEASE_RST;
			det_r = DETECTOR_RST;
			hold_len_r = HOLD_LEN_RST;
			range_r = RANGE_RST;
			en_r = ENABLE_RST;
			env_q = '0;
			hold_ctr = '0;
			gain_q = '0;
			gated_q.delete();
			mismatches = 0;
			checked = 0;
			opened = 0;
			outstanding <= 0;
			fail_count <= 0;
			results_seen <= 0;
			open_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_addr))
					REG_THRESHOLD: thr_r = cfg_wdata[SMP_W-1:0];
					REG_ATTACK:    atk_r = cfg_wdata;
					REG_RELEASE:   rel_r = cfg_wdata;
					REG_DETECTOR:  det_r = cfg_wdata;
					REG_HOLD_LEN:  hold_len_r = cfg_wdata[HL_W-1:0];
					REG_RANGE:     range_r = cfg_wdata;
					REG_ENABLE:    en_r = cfg_wdata[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				gate_sample(sample_in, want_r);
				gated_q.push_back(want_r);
			end
			if (out_valid && out_ready) begin
				if (gated_q.size() == 0) begin
					report($sformatf("output transfer with nothing pending: %h %b",
						sample_out, gate_open));
				end else begin
					want_r = gated_q.pop_front();
					if (sample_out !== want_r.smp) begin
						report($sformatf("result %0d sample_out %h, want %h",
							checked, sample_out, want_r.smp));
					end
					if (gate_open !== want_r.open) begin
						report($sformatf("result %0d gate_open %b, want %b",
							checked, gate_open, want_r.open));
					end
					checked++;
					if (want_r.open) begin
						opened++;
					end
				end
			end
			outstanding <= gated_q.size();
			fail_count <= mismatches;
			results_seen <= checked;
			open_seen <= opened;
		end
	end

endmodule

/* tb/tb_noise_gate_hold_smoothed.sv */
// testbench top for the noise gate: clock, reset, stimulus, output stalls and verdict
`timescale 1ns / 1ps

module tb_noise_gate_hold_smoothed;
	import ngh_pkg::*;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [SMP_W-1:0] sample_in;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [SMP_W-1:0] sample_out;
	logic                    gate_open;
	logic                    cfg_we;
	logic [IDX_W-1:0]        cfg_addr;
	logic [Q_W-1:0]          cfg_wdata;

	int fail_count;
	int outstanding;
	int results_seen;
	int open_seen;

	int items_sent;
	int settings_used;
	int burst_left;
	int cur_threshold;

	noise_gate_hold_smoothed DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.gate_open  (gate_open),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata)
	);

	noise_gate_hold_smoothed_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_in    (sample_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out),
		.gate_open    (gate_open),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.open_seen    (open_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#32_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// output stall pattern
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 300);
			end
			left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 0);
				2: out_ready <= ($urandom_range(0, 7) == 0);
				default: out_ready <= (left % 5 == 0);
			endcase
		end
	end

	task automatic send_sample(input logic [SMP_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 130);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		sample_in <= v;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [Q_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic apply_setting(input int thr, input logic [Q_W-1:0] atk,
			input logic [Q_W-1:0] rel, input logic [Q_W-1:0] det,
			input logic [HL_W-1:0] hold, input logic [Q_W-1:0] rng, input logic en);
		drain();
		write_reg(REG_THRESHOLD, Q_W'(thr));
		write_reg(REG_ATTACK, atk);
		write_reg(REG_RELEASE, rel);
		write_reg(REG_DETECTOR, det);
		write_reg(REG_HOLD_LEN, Q_W'(hold));
		write_reg(REG_RANGE, rng);
		write_reg(REG_ENABLE, Q_W'(en));
		cfg_we <= 1'b0;
		cur_threshold = thr;
		settings_used++;
	endtask

	function automatic logic [SMP_W-1:0] from_mag(input int m, input logic neg);
		if (neg) begin
			return SMP_W'(-m);
		end
		return (m > 32767) ? SMP_W'(32767) : SMP_W'(m);
	endfunction

	// loud passages, quiet passages, full-range noise and the extremes
	function automatic logic [SMP_W-1:0] shaped_sample(input int kind);
		int lvl;
		lvl = (cur_threshold > 32768) ? 32768 : cur_threshold;
		if (kind <= 3) begin
			return from_mag($urandom_range(lvl, 32768), ($urandom_range(0, 1) == 1));
		end else if (kind <= 6) begin
			return from_mag($urandom_range(0, lvl / 2), ($urandom_range(0, 1) == 1));
		end else if (kind <= 8) begin
			return SMP_W'($urandom);
		end
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'hffff;
		endcase
	endfunction

	function automatic logic [Q_W-1:0] pick_coeff();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return Q24_ONE;
			2: return '1;
			3: return Q_W'($urandom_range(32'h100_0001, 32'h1ff_ffff));
			4: return Q_W'($urandom_range(1, 32'h1_0000));
			default: return Q_W'($urandom_range(32'h1_0000, 32'h100_0000));
		endcase
	endfunction

	function automatic logic [Q_W-1:0] pick_detector();
		if ($urandom_range(0, 3) == 0) begin
			return pick_coeff();
		end
		return Q_W'($urandom_range(32'h4_0000, 32'h100_0000));
	endfunction

	function automatic int pick_threshold();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 32768;
			2: return 65535;
			3: return $urandom_range(0, 65535);
			default: return $urandom_range(1, 32768);
		endcase
	endfunction

	function automatic logic [HL_W-1:0] pick_hold();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return HL_W'(1);
			2: return '1;
			3: return HL_W'($urandom_range(0, 131071));
			4, 5: return HL_W'($urandom_range(0, 300));
			default: return HL_W'($urandom_range(0, 16));
		endcase
	endfunction

	task automatic run_phase(input int count);
		int done_items;
		int len;
		int kind;
		int k;
		done_items = 0;
		while (done_items < count) begin
			kind = $urandom_range(0, 9);
			len = $urandom_range(1, 40);
			if ($urandom_range(0, 24) == 0) begin
				drain();
			end
			for (k = 0; k < len && done_items < count; k++) begin
				send_sample(shaped_sample(kind));
				done_items++;
			end
		end
	endtask

	initial begin
		int p;
		in_valid <= 1'b0;
		sample_in <= '0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_THRESHOLD;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		items_sent = 0;
		settings_used = 1;
		burst_left = 0;
		cur_threshold = THRESHOLD_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults, field extremes and the threshold edge
		send_sample(16'h7fff);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hffff);
		send_sample(16'h0001);
		send_sample(16'd3277);
		send_sample(16'd3276);
		send_sample(-16'sd3277);

		// coefficients above one, no hold: gain snaps and settles at its target
		apply_setting(1000, '1, '1, '1, '0, '1, 1'b1);
		send_sample(16'd20000);
		send_sample(16'h0000);
		send_sample(16'h0000);
		send_sample(16'h8000);
		send_sample(16'h0000);

		// threshold beyond full scale with the longest hold
		apply_setting(65535, Q24_ONE, Q24_ONE, Q24_ONE, '1, Q24_ONE, 1'b1);
		send_sample(16'h7fff);
		send_sample(16'h8000);
		send_sample(16'h0005);

		// bypass
		apply_setting(3277, ATTACK_RST, RELEASE_RST, DETECTOR_RST, HOLD_LEN_RST, RANGE_RST, 1'b0);
		send_sample(16'h7fff);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'h1234);

		apply_setting(THRESHOLD_RST, ATTACK_RST, RELEASE_RST, DETECTOR_RST, HOLD_LEN_RST,
			RANGE_RST, ENABLE_RST);
		run_phase(185);
		for (p = 0; p < 9; p++) begin
			apply_setting(pick_threshold(), pick_coeff(), pick_coeff(), pick_detector(),
				pick_hold(), pick_coeff(), ($urandom_range(0, 7) != 0));
			run_phase(185);
		end

		drain();
		repeat (120) @(posedge clk);
		$display("run covered %0d samples under %0d register settings",
			items_sent, settings_used);
		$display("%0d gated samples compared, gate open on %0d of them", results_seen, open_seen);
		if (fail_count == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
